>>> hw/rtl/ocit_pkg.sv
package ocit_pkg;

  typedef enum logic [2:0] {
    OP_ADD     = 3'd0,
    OP_REMOVE  = 3'd1,
    OP_FIND    = 3'd2,
    OP_ALL_AT  = 3'd3,
    OP_CALLS   = 3'd4,
    OP_PUTS    = 3'd5,
    OP_EXPIRY  = 3'd6,
    OP_ON_BEF  = 3'd7
  } op_t;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_REJECT = 2'd1;
  localparam logic [1:0] ST_EMPTY  = 2'd2;
  localparam logic [1:0] ST_FULL   = 2'd3;

  typedef struct packed {
    logic [31:0] id;
    logic [31:0] expiry;
    logic [31:0] strike;
    logic        is_call;
  } entry_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] id;
    logic [31:0] expiry;
    logic        last;
  } result_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_WRITE,
    S_EMIT,
    S_DONE
  } state_t;

  // Key order: expiry, then strike, then call before put. -1 / 0 / +1 as 2 bits.
  function automatic logic [1:0] key_cmp(input entry_t a, input entry_t b);
    logic ra;
    logic rb;
    ra = ~a.is_call;
    rb = ~b.is_call;
    if (a.expiry != b.expiry) return (a.expiry < b.expiry) ? 2'b11 : 2'b01;
    if (a.strike != b.strike) return (a.strike < b.strike) ? 2'b11 : 2'b01;
    if (ra != rb) return (ra < rb) ? 2'b11 : 2'b01;
    return 2'b00;
  endfunction

endpackage

>>> hw/rtl/option_chain_index_table_top.sv
// Sorted index of option instruments held in one synchronous memory.
// Input channel in_*: one operation per transfer (add, remove, find, lists).
// Output channel out_*: one or more results per operation; out_last marks
// the final one. Lists stream ids (or distinct expiries) in key order, with
// one candidate held back so the final one can carry last; a list with
// nothing to report gives one result with status empty.
// Each operation sweeps the packed table, one memory read per cycle unless
// the receiver stalls it. An add or remove then moves entries one at a
// time, each with a read and then a write. One item is in work at a time;
// in_ready is low until its last result is loaded into the output register.
// A stalled receiver holds the result in that register and freezes the
// sweep at the next result. Reset empties the table (entry count to zero);
// memory contents need no clearing.
module option_chain_index_table_top
  import ocit_pkg::*;
#(
  parameter int ENTRIES = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_op,
  input  logic [31:0] in_instrument_id,
  input  logic [31:0] in_expiry,
  input  logic [31:0] in_strike,
  input  logic        in_is_call,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [31:0] out_result_id,
  output logic [31:0] out_result_expiry,
  output logic        out_last
);

  localparam int AW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES + 1);

  state_t          state_r, state_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic [CW-1:0]   idx_r, idx_nxt;      // index whose read data arrives this cycle
  logic [CW-1:0]   pos_r, pos_nxt;      // hit or insert position
  logic            hit_r, hit_nxt;      // id found on add or remove
  logic            any_r, any_nxt;      // key taken on add / list candidate held
  logic            first_r, first_nxt;
  logic            rd_pend_r, rd_pend_nxt;
  logic [2:0]      op_r;
  entry_t          key_r;
  logic [31:0]     prev_exp_r, prev_exp_nxt;
  result_t         res_r, res_nxt;
  result_t         pend_r, pend_nxt;    // list candidate not yet sent
  logic            ovalid_r, ovalid_nxt;

  logic            we;
  logic [AW-1:0]   waddr, raddr;
  entry_t          wdata, rdata;
  logic [CW-1:0]   raddr_full;

  ocit_mem #(.ENTRIES(ENTRIES), .AW(AW)) u_mem (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  assign raddr = raddr_full[AW-1:0];

  assign in_ready          = (state_r == S_IDLE);
  assign out_valid         = ovalid_r;
  assign out_status        = res_r.status;
  assign out_result_id     = res_r.id;
  assign out_result_expiry = res_r.expiry;
  assign out_last          = res_r.last;

  logic out_free;
  assign out_free = ~ovalid_r | out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      count_r  <= '0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    pos_r      <= pos_nxt;
    hit_r      <= hit_nxt;
    any_r      <= any_nxt;
    first_r    <= first_nxt;
    rd_pend_r  <= rd_pend_nxt;
    prev_exp_r <= prev_exp_nxt;
    res_r      <= res_nxt;
    pend_r     <= pend_nxt;
    if (in_valid && in_ready) begin
      op_r          <= in_op;
      key_r.id      <= in_instrument_id;
      key_r.expiry  <= in_expiry;
      key_r.strike  <= in_strike;
      key_r.is_call <= in_is_call;
    end
  end

  logic [1:0] cmp;
  logic       take;
  logic       is_add, is_rem;
  assign cmp    = key_cmp(key_r, rdata);
  assign is_add = (op_r == OP_ADD);
  assign is_rem = (op_r == OP_REMOVE);

  always_comb begin
    unique case (op_r)
      OP_ON_BEF: take = (rdata.expiry <= key_r.expiry);
      OP_ALL_AT: take = (rdata.expiry == key_r.expiry);
      OP_CALLS:  take = (rdata.expiry == key_r.expiry) && rdata.is_call;
      OP_PUTS:   take = (rdata.expiry == key_r.expiry) && !rdata.is_call;
      OP_EXPIRY: take = first_r || (rdata.expiry != prev_exp_r);
      default:   take = 1'b0;
    endcase
  end

  always_comb begin
    state_nxt    = state_r;
    count_nxt    = count_r;
    idx_nxt      = idx_r;
    pos_nxt      = pos_r;
    hit_nxt      = hit_r;
    any_nxt      = any_r;
    first_nxt    = first_r;
    rd_pend_nxt  = 1'b0;
    prev_exp_nxt = prev_exp_r;
    res_nxt      = res_r;
    pend_nxt     = pend_r;
    ovalid_nxt   = ovalid_r & ~out_ready;
    raddr_full   = idx_r;
    we           = 1'b0;
    waddr        = pos_r[AW-1:0];
    wdata        = key_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          idx_nxt     = '0;
          pos_nxt     = count_r;
          hit_nxt     = 1'b0;
          any_nxt     = 1'b0;
          first_nxt   = 1'b1;
          raddr_full  = '0;
          rd_pend_nxt = 1'b1;
          state_nxt   = S_SCAN;
        end
      end

      // rdata holds entry idx_r when rd_pend_r; results go out only when free.
      S_SCAN: begin
        if (!rd_pend_r) begin
          raddr_full  = idx_r;
          rd_pend_nxt = (idx_r < count_r);
          if (idx_r >= count_r) state_nxt = S_EMIT;
        end else if (idx_r >= count_r) begin
          state_nxt = S_EMIT;
        end else if (op_r == OP_ADD || op_r == OP_REMOVE) begin
          // Pass 1 finds the id; any other match on add is handled too.
          if (rdata.id == key_r.id) begin
            hit_nxt   = 1'b1;
            pos_nxt   = idx_r;
            state_nxt = S_EMIT;
          end else begin
            if (is_add && !hit_r && cmp == 2'b00) begin
              any_nxt = 1'b1;             // key taken; keep scanning for id
            end
            if (is_add && !any_r && !any_nxt && cmp == 2'b11 && pos_r == count_r)
              pos_nxt = idx_r;
            idx_nxt     = idx_r + 1'b1;
            raddr_full  = idx_r + 1'b1;
            rd_pend_nxt = 1'b1;
          end
        end else if (op_r == OP_FIND) begin
          if (cmp == 2'b00) begin
            if (out_free) begin
              res_nxt    = '{ST_OK, rdata.id, 32'd0, 1'b1};
              ovalid_nxt = 1'b1;
              state_nxt  = S_IDLE;
            end else begin
              raddr_full  = idx_r;        // hold: reread same entry
              rd_pend_nxt = 1'b1;
            end
          end else begin
            idx_nxt     = idx_r + 1'b1;
            raddr_full  = idx_r + 1'b1;
            rd_pend_nxt = 1'b1;
          end
        end else begin
          if (take && any_r && !out_free) begin
            raddr_full  = idx_r;          // hold: reread same entry
            rd_pend_nxt = 1'b1;
          end else begin
            if (take) begin
              // a new candidate means the held one is not the last
              if (any_r) begin
                res_nxt    = pend_r;
                ovalid_nxt = 1'b1;
              end
              any_nxt = 1'b1;
              if (op_r == OP_EXPIRY) pend_nxt = '{ST_OK, 32'd0, rdata.expiry, 1'b0};
              else                   pend_nxt = '{ST_OK, rdata.id, 32'd0, 1'b0};
            end
            first_nxt    = 1'b0;
            prev_exp_nxt = rdata.expiry;
            idx_nxt      = idx_r + 1'b1;
            raddr_full   = idx_r + 1'b1;
            rd_pend_nxt  = 1'b1;
          end
        end
      end

      // Decide: answer reject or full, start the shift sweep (or the write) for add/remove, or pass a list on to close.
      S_EMIT: begin
        if (out_free) begin
          if (is_add) begin
            if (hit_r || any_r) begin
              res_nxt = '{ST_REJECT, 32'd0, 32'd0, 1'b1};
              ovalid_nxt = 1'b1; state_nxt = S_IDLE;
            end else if (count_r == CW'(ENTRIES)) begin
              res_nxt = '{ST_FULL, 32'd0, 32'd0, 1'b1};
              ovalid_nxt = 1'b1; state_nxt = S_IDLE;
            end else begin
              idx_nxt = count_r;         // move entries up from the top
              if (count_r != pos_r) begin
                raddr_full  = count_r - 1'b1;
                rd_pend_nxt = 1'b1;
                state_nxt   = S_SHIFT;
              end else begin
                state_nxt = S_WRITE;
              end
            end
          end else if (is_rem) begin
            if (!hit_r) begin
              res_nxt = '{ST_REJECT, 32'd0, 32'd0, 1'b1};
              ovalid_nxt = 1'b1; state_nxt = S_IDLE;
            end else begin
              idx_nxt = pos_r;           // move entries down from the hit
              if (pos_r + 1'b1 < count_r) begin
                raddr_full  = pos_r + 1'b1;
                rd_pend_nxt = 1'b1;
                state_nxt   = S_SHIFT;
              end else begin
                state_nxt = S_WRITE;
              end
            end
          end else if (op_r == OP_FIND) begin
            res_nxt = '{ST_REJECT, 32'd0, 32'd0, 1'b1};
            ovalid_nxt = 1'b1; state_nxt = S_IDLE;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end

      // One moved entry per read-modify-write pair.
      S_SHIFT: begin
        if (!rd_pend_r) begin
          raddr_full  = is_add ? idx_r - 1'b1 : idx_r + 1'b1;
          rd_pend_nxt = 1'b1;
        end else begin
          we      = 1'b1;
          waddr   = idx_r[AW-1:0];
          wdata   = rdata;
          if (is_add) begin
            idx_nxt = idx_r - 1'b1;
            if (idx_r - 1'b1 == pos_r) state_nxt = S_WRITE;
          end else begin
            idx_nxt = idx_r + 1'b1;
            if (idx_r + CW'(2) >= count_r) state_nxt = S_WRITE;
          end
        end
      end

      S_WRITE: begin
        if (is_add) begin
          we        = 1'b1;
          waddr     = pos_r[AW-1:0];
          count_nxt = count_r + 1'b1;
        end else begin
          count_nxt = count_r - 1'b1;
        end
        res_nxt    = '{ST_OK, 32'd0, 32'd0, 1'b1};
        ovalid_nxt = 1'b1;
        state_nxt  = S_IDLE;
      end

      // Close a list: send the held candidate flagged last, or an empty status.
      S_DONE: begin
        if (out_free) begin
          if (any_r) begin
            res_nxt      = pend_r;
            res_nxt.last = 1'b1;
          end else begin
            res_nxt = '{ST_EMPTY, 32'd0, 32'd0, 1'b1};
          end
          ovalid_nxt = 1'b1;
          state_nxt  = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  property p_ready_idle;
    @(posedge clk) disable iff (!rst_n) in_ready |-> (state_r == S_IDLE);
  endproperty
  a_ready_idle: assert property (p_ready_idle) else $error("ready outside idle");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(ENTRIES)) else $error("entry count overflow");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_result_id))
    else $error("result dropped under stall");

endmodule

>>> hw/rtl/ocit_mem.sv
module ocit_mem
  import ocit_pkg::*;
#(
  parameter int ENTRIES = 32,
  parameter int AW = 5
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  entry_t        wdata,
  input  logic [AW-1:0] raddr,
  output entry_t        rdata
);

  entry_t mem [ENTRIES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> tb/option_chain_index_table_checker.sv
module option_chain_index_table_checker
  import ocit_pkg::*;
#(
  parameter int ENTRIES = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [2:0]  in_op,
  input  logic [31:0] in_instrument_id,
  input  logic [31:0] in_expiry,
  input  logic [31:0] in_strike,
  input  logic        in_is_call,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [1:0]  out_status,
  input  logic [31:0] out_result_id,
  input  logic [31:0] out_result_expiry,
  input  logic        out_last,
  output int          fail_count,
  output int          pending,
  output int          table_size,
  output int          results_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  entry_t  chain[$];
  result_t expected_results[$];

  // -1 if key a sorts before b, 0 if equal, 1 after
  function automatic int order_keys(entry_t a, entry_t b);
    if (a.expiry != b.expiry) return (a.expiry < b.expiry) ? -1 : 1;
    if (a.strike != b.strike) return (a.strike < b.strike) ? -1 : 1;
    if (a.is_call != b.is_call) return a.is_call ? -1 : 1;
    return 0;
  endfunction

  task automatic push_result(logic [1:0] st, logic [31:0] id, logic [31:0] ex);
    result_t r;
    r.status = st;
    r.id     = id;
    r.expiry = ex;
    r.last   = 1'b0;
    expected_results.insert(expected_results.size(), r);
  endtask

  task automatic apply_operation(op_t op, entry_t e);
    int n;
    int pos;
    int hit;
    logic [1:0] st;
    bit take;
    n = expected_results.size();
    pos = chain.size();
    hit = -1;
    st = ST_OK;
    for (int i = 0; i < chain.size(); i++) begin
      if (chain[i].id == e.id) begin
        hit = i;
        break;
      end
    end
    case (op)
      OP_ADD: begin
        if (hit >= 0) begin
          st = ST_REJECT;
        end else begin
          for (int i = 0; i < chain.size(); i++) begin
            if (order_keys(e, chain[i]) == 0) begin
              st = ST_REJECT;
              break;
            end
            if (order_keys(e, chain[i]) < 0) begin
              pos = i;
              break;
            end
          end
          if (st == ST_OK && chain.size() >= ENTRIES) st = ST_FULL;
        end
        if (st == ST_OK) chain.insert(pos, e);
        push_result(st, '0, '0);
      end
      OP_REMOVE: begin
        if (hit >= 0) chain.delete(hit);
        push_result((hit >= 0) ? ST_OK : ST_REJECT, '0, '0);
      end
      OP_FIND: begin
        hit = -1;
        for (int i = 0; i < chain.size(); i++) begin
          if (order_keys(e, chain[i]) == 0) begin
            hit = i;
            break;
          end
        end
        if (hit >= 0) push_result(ST_OK, chain[hit].id, '0);
        else push_result(ST_REJECT, '0, '0);
      end
      OP_EXPIRY: begin
        for (int i = 0; i < chain.size(); i++) begin
          if (i == 0 || chain[i].expiry != chain[i-1].expiry)
            push_result(ST_OK, '0, chain[i].expiry);
        end
      end
      default: begin
        foreach (chain[i]) begin
          case (op)
            OP_ON_BEF: take = chain[i].expiry <= e.expiry;
            OP_ALL_AT: take = chain[i].expiry == e.expiry;
            OP_CALLS:  take = chain[i].expiry == e.expiry && chain[i].is_call;
            default:   take = chain[i].expiry == e.expiry && !chain[i].is_call;
          endcase
          if (take) push_result(ST_OK, chain[i].id, '0);
        end
      end
    endcase
    if (expected_results.size() == n) push_result(ST_EMPTY, '0, '0);
    expected_results[expected_results.size()-1].last = 1'b1;
  endtask

  assign pending    = expected_results.size();
  assign table_size = chain.size();

  always @(posedge clk) begin
    entry_t  e;
    result_t want;
    if (!rst_n) begin
      fail_count   <= 0;
      results_seen <= 0;
      chain.delete();
      expected_results.delete();
    end else begin
      // check the result before predicting, so an item never meets its own results early
      if (out_valid && out_ready) begin
        results_seen <= results_seen + 1;
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result status=%0d id=%h expiry=%h last=%b",
                   $time, out_status, out_result_id, out_result_expiry, out_last);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_results.pop_front();
          if (out_status !== want.status || out_result_id !== want.id ||
              out_result_expiry !== want.expiry || out_last !== want.last) begin
            $display("%0t: mismatch expected status=%0d id=%h expiry=%h last=%b",
                     $time, want.status, want.id, want.expiry, want.last);
            $display("%0t:          actual   status=%0d id=%h expiry=%h last=%b",
                     $time, out_status, out_result_id, out_result_expiry, out_last);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_valid && in_ready) begin
        e.id      = in_instrument_id;
        e.expiry  = in_expiry;
        e.strike  = in_strike;
        e.is_call = in_is_call;
        apply_operation(op_t'(in_op), e);
      end
    end
  end

endmodule

>>> tb/tb_option_chain_index_table_top.sv
module tb_option_chain_index_table_top;
  import ocit_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ENTRIES = 32;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [2:0]  in_op;
  logic [31:0] in_instrument_id;
  logic [31:0] in_expiry;
  logic [31:0] in_strike;
  logic        in_is_call;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  out_status;
  logic [31:0] out_result_id;
  logic [31:0] out_result_expiry;
  logic        out_last;
  int          fail_count;
  int          pending;
  int          table_size;
  int          results_seen;

  int          send_idle_pct;
  int          recv_stall_pct;
  int          hold_off_cycles;
  logic        hold_req;
  int          items_sent;
  int          sample_ids[$];

  option_chain_index_table_top #(.ENTRIES(ENTRIES)) u_dut (.*);

  option_chain_index_table_checker #(.ENTRIES(ENTRIES)) u_checker (.*);

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #50ms;
    $display("timeout");
    $display("tb: failure");
    $finish;
  end

  // receiver: random stall, or a long hold-off when requested
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready       <= 1'b0;
      hold_off_cycles <= 0;
    end else if (hold_req) begin
      hold_off_cycles <= 300;
      out_ready       <= 1'b0;
    end else if (hold_off_cycles > 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic send_item(op_t op, logic [31:0] id, logic [31:0] ex,
                           logic [31:0] sk, logic call);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_op            <= op;
    in_instrument_id <= id;
    in_expiry        <= ex;
    in_strike        <= sk;
    in_is_call       <= call;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
    if (op == OP_ADD) sample_ids.insert(sample_ids.size(), id);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (2 * ENTRIES + 10) @(posedge clk);
  endtask

  // mostly well-formed content from a small key space, so adds hit and collide
  task automatic send_random();
    int kind;
    logic [31:0] id;
    logic [31:0] ex;
    logic [31:0] sk;
    kind = $urandom_range(99);
    ex = (kind < 10) ? $urandom() : 32'd100 + $urandom_range(5);
    sk = (kind < 10) ? $urandom() : 32'd1000 + 10 * $urandom_range(3);
    if (sample_ids.size() > 0 && $urandom_range(1))
      id = sample_ids[$urandom_range(sample_ids.size() - 1)];
    else
      id = $urandom();
    if (kind < 40)
      send_item(OP_ADD, id, ex, sk, 1'($urandom_range(1)));
    else if (kind < 55)
      send_item(OP_REMOVE, id, ex, sk, 1'($urandom_range(1)));
    else
      send_item(op_t'($urandom_range(2, 7)), id, ex, sk, 1'($urandom_range(1)));
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_op = OP_ADD;
    in_instrument_id = '0;
    in_expiry = '0;
    in_strike = '0;
    in_is_call = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_req = 1'b0;
    items_sent = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty lists, extremes, rejects, cutoff equality
    send_item(OP_EXPIRY, 32'd0, 32'd0, 32'd0, 1'b0);
    send_item(OP_FIND, 32'd0, 32'd0, 32'd0, 1'b1);
    send_item(OP_REMOVE, 32'd5, 32'd0, 32'd0, 1'b0);
    send_item(OP_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    send_item(OP_ADD, 32'd0, 32'd0, 32'd0, 1'b0);
    send_item(OP_ADD, 32'd7, 32'd50, 32'd20, 1'b0);
    send_item(OP_ADD, 32'd8, 32'd50, 32'd20, 1'b1);
    send_item(OP_ADD, 32'd7, 32'd60, 32'd1, 1'b1);
    send_item(OP_ADD, 32'd9, 32'd50, 32'd20, 1'b1);
    send_item(OP_FIND, 32'd0, 32'd50, 32'd20, 1'b1);
    send_item(OP_FIND, 32'd0, 32'd50, 32'd21, 1'b1);
    send_item(OP_ALL_AT, 32'd0, 32'd50, 32'd0, 1'b0);
    send_item(OP_CALLS, 32'd0, 32'd50, 32'd0, 1'b0);
    send_item(OP_PUTS, 32'd0, 32'd50, 32'd0, 1'b0);
    send_item(OP_PUTS, 32'd0, 32'd51, 32'd0, 1'b0);
    send_item(OP_EXPIRY, 32'd0, 32'd0, 32'd0, 1'b0);
    send_item(OP_ON_BEF, 32'd0, 32'd50, 32'd0, 1'b0);
    send_item(OP_ON_BEF, 32'd0, 32'd49, 32'd0, 1'b0);
    send_item(OP_ON_BEF, 32'd0, 32'hFFFF_FFFF, 32'd0, 1'b0);
    send_item(OP_REMOVE, 32'd8, 32'd0, 32'd0, 1'b0);
    // fill the table, then overflow it and try a taken key when full
    for (int i = 0; i < ENTRIES; i++)
      send_item(OP_ADD, 32'h1000 + i, 32'd200 + i / 4, $urandom(), i[0]);
    send_item(OP_ADD, 32'h5555_AAAA, 32'd1, 32'd1, 1'b1);
    send_item(OP_ADD, 32'h6666_0000, 32'd50, 32'd20, 1'b0);
    send_item(OP_EXPIRY, 32'd0, 32'd0, 32'd0, 1'b0);
    send_item(OP_ON_BEF, 32'd0, 32'hFFFF_FFFF, 32'd0, 1'b0);
    for (int i = 0; i < ENTRIES; i++)
      send_item(OP_REMOVE, 32'h1000 + i, 32'd0, 32'd0, 1'b0);

    // hold off the receiver while the sender keeps offering
    hold_req <= 1'b1;
    @(posedge clk);
    hold_req <= 1'b0;
    repeat (8) send_random();
    drain();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 78; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 78; end
        default: begin send_idle_pct = 13; recv_stall_pct = 13; end
      endcase
      repeat (30) send_random();
      // pause until every expected result has come
      drain();
    end

    $display("run: %0d items, %0d results, final table size %0d of %0d",
             items_sent, results_seen, table_size, ENTRIES);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

>>> files.f
hw/rtl/ocit_pkg.sv
hw/rtl/ocit_mem.sv
hw/rtl/option_chain_index_table_top.sv
tb/option_chain_index_table_checker.sv
tb/tb_option_chain_index_table_top.sv
